// ===== hdl/toh_pkg.sv =====
// shared constants, types and codes for the tile occupancy hysteresis block
// no dependencies

package toh_pkg;

  // sensor and tile grid
  localparam int unsigned PIXEL_COLS = 101;
  localparam int unsigned PIXEL_ROWS = 101;
  localparam int unsigned TILE_COLS  = 31;
  localparam int unsigned TILE_ROWS  = 31;
  localparam int unsigned TILE_COUNT = TILE_COLS * TILE_ROWS;
  localparam int unsigned IDX_W      = $clog2(TILE_COUNT);

  // field widths
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned TILE_W   = 5;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned MEM_W    = SUM_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM = 1'b1;
  localparam logic [CFG_DATA_W-1:0] FIRE_RESET  = 24'd2200;
  localparam logic [CFG_DATA_W-1:0] REARM_RESET = 24'd250;

  // operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SETTLE = 1'b1;

  // coordinate mapping: round(c * tiles / pixels) as a reciprocal multiply
  localparam int unsigned MAP_NUM_W = 16;
  localparam int unsigned MAP_MUL_W = 18;
  localparam int unsigned MAP_SHIFT = 24;
  localparam int unsigned MAP_MUL_COL = ((2**MAP_SHIFT) + 2*PIXEL_COLS - 1) / (2*PIXEL_COLS);
  localparam int unsigned MAP_MUL_ROW = ((2**MAP_SHIFT) + 2*PIXEL_ROWS - 1) / (2*PIXEL_ROWS);

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic               op;
    logic [TILE_W-1:0]  row;
    logic [TILE_W-1:0]  col;
    logic [VALUE_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef struct packed {
    logic [SUM_W-1:0] fire;
    logic [SUM_W-1:0] rearm;
  } thr_t;

  typedef struct packed {
    logic [TILE_W-1:0] row;
    logic [TILE_W-1:0] col;
  } res_t;

endpackage

// ===== hdl/toh_if.sv =====
// item channel interfaces for the input and result sides
// depends on toh_pkg

interface toh_in_if import toh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  logic [VALUE_W-1:0] pixel_value;

  modport source (output valid, output operation, output pixel_col, output pixel_row,
                  output pixel_value, input ready);
  modport sink (input valid, input operation, input pixel_col, input pixel_row,
                input pixel_value, output ready);
endinterface

interface toh_out_if import toh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_row;
  logic [TILE_W-1:0] tile_col;

  modport source (output valid, output tile_row, output tile_col, input ready);
  modport sink (input valid, input tile_row, input tile_col, output ready);
endinterface

// ===== hdl/toh_front.sv =====
// front end: accepts items, maps pixels to tiles, assigns sweep tiles to settles
// depends on toh_pkg and toh_if

module toh_front import toh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  toh_in_if.sink       in_chan,
  input  q_status_t    q_stat,
  input  back_status_t back_stat,
  output logic         push,
  output q_entry_t     push_entry
);

  logic [TILE_W-1:0] sw_row_r, sw_row_nxt;
  logic [TILE_W-1:0] sw_col_r, sw_col_nxt;
  logic              accept;
  logic              is_settle;

  function automatic logic [TILE_W-1:0] map_axis(
    input logic [COORD_W-1:0]   c,
    input int unsigned          tiles,
    input int unsigned          pixels,
    input logic [MAP_MUL_W-1:0] mul
  );
    logic [MAP_NUM_W-1:0]           num;
    logic [MAP_NUM_W+MAP_MUL_W-1:0] prod;
    logic [MAP_NUM_W+MAP_MUL_W-1:0] q;
    num  = MAP_NUM_W'({c, 1'b0}) * MAP_NUM_W'(tiles) + MAP_NUM_W'(pixels);
    prod = (MAP_NUM_W+MAP_MUL_W)'(num) * (MAP_NUM_W+MAP_MUL_W)'(mul);
    q    = prod >> MAP_SHIFT;
    if (q > (MAP_NUM_W+MAP_MUL_W)'(tiles - 1)) begin
      q = (MAP_NUM_W+MAP_MUL_W)'(tiles - 1);
    end
    return TILE_W'(q);
  endfunction

  assign in_chan.ready = !q_stat.full && !back_stat.clearing;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_settle     = (in_chan.operation == OP_SETTLE);
  assign push          = accept;

  always_comb begin
    push_entry.op    = in_chan.operation;
    push_entry.value = in_chan.pixel_value;
    if (is_settle) begin
      push_entry.row = sw_row_r;
      push_entry.col = sw_col_r;
    end else begin
      push_entry.row = map_axis(in_chan.pixel_row, TILE_ROWS, PIXEL_ROWS,
                                MAP_MUL_W'(MAP_MUL_ROW));
      push_entry.col = map_axis(in_chan.pixel_col, TILE_COLS, PIXEL_COLS,
                                MAP_MUL_W'(MAP_MUL_COL));
    end
  end

  // sweep position kept as row and column, row-major
  always_comb begin
    sw_row_nxt = sw_row_r;
    sw_col_nxt = sw_col_r;
    if (accept && is_settle) begin
      if (sw_col_r == TILE_W'(TILE_COLS - 1)) begin
        sw_col_nxt = '0;
        sw_row_nxt = (sw_row_r == TILE_W'(TILE_ROWS - 1)) ? '0 : sw_row_r + 1'b1;
      end else begin
        sw_col_nxt = sw_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_row_r <= '0;
      sw_col_r <= '0;
    end else begin
      sw_row_r <= sw_row_nxt;
      sw_col_r <= sw_col_nxt;
    end
  end

endmodule

// ===== hdl/toh_queue.sv =====
// small fifo of classified items between front and back
// depends on toh_pkg

module toh_queue import toh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t stat
);

  q_entry_t           buf_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign head          = buf_r[rp_r];
  assign stat.full     = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.nonempty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

endmodule

// ===== hdl/toh_back.sv =====
// back end: tile memory read-modify-write, hysteresis and result buffer
// depends on toh_pkg and toh_if

module toh_back import toh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  q_entry_t     head,
  input  q_status_t    q_stat,
  input  thr_t         thr,
  output logic         pop,
  output back_status_t stat,
  toh_out_if.source    out_chan
);

  // memory word: {fired mark, tile sum}
  logic [MEM_W-1:0] mem_r [TILE_COUNT];
  logic [MEM_W-1:0] mem_rd_r;

  logic             clr_active_r;
  logic [IDX_W-1:0] clr_addr_r;

  logic               e_valid_r;
  logic               e_op_r;
  logic [IDX_W-1:0]   e_addr_r;
  logic [TILE_W-1:0]  e_row_r;
  logic [TILE_W-1:0]  e_col_r;
  logic [VALUE_W-1:0] e_value_r;

  logic             fwd_valid_r;
  logic [IDX_W-1:0] fwd_addr_r;
  logic [MEM_W-1:0] fwd_data_r;

  res_t       ob_r [2];
  logic       ob_wp_r, ob_rp_r;
  logic [1:0] ob_cnt_r;
  logic [1:0] ob_load;
  logic       ob_push, ob_pop;

  logic [IDX_W-1:0] rd_addr;
  logic [MEM_W-1:0] old_word;
  logic [SUM_W-1:0] old_sum;
  logic             old_mark;
  logic [SUM_W:0]   add_sum;
  logic [SUM_W-1:0] half_sum;
  logic             fire;
  logic [MEM_W-1:0] wr_word;

  assign stat.clearing = clr_active_r;

  // results already buffered plus a settle that may still produce one
  assign ob_load = ob_cnt_r + {1'b0, e_valid_r && (e_op_r == OP_SETTLE)};
  assign pop     = q_stat.nonempty && !clr_active_r && (ob_load <= 2'd1);
  assign rd_addr = IDX_W'(head.row) * IDX_W'(TILE_COLS) + IDX_W'(head.col);

  // the write of the previous item has not reached the read yet
  assign old_word = (fwd_valid_r && (fwd_addr_r == e_addr_r)) ? fwd_data_r : mem_rd_r;
  assign old_sum  = old_word[SUM_W-1:0];
  assign old_mark = old_word[SUM_W];
  assign add_sum  = {1'b0, old_sum} + (SUM_W+1)'(e_value_r);
  assign half_sum = old_sum >> 1;
  assign fire     = (e_op_r == OP_SETTLE) && (half_sum > thr.fire) && !old_mark;

  always_comb begin
    unique case (e_op_r)
      OP_ADD: begin
        wr_word = {old_mark, add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0]};
      end
      OP_SETTLE: begin
        priority if (fire) begin
          wr_word = {1'b1, half_sum};
        end else if (half_sum < thr.rearm) begin
          wr_word = {1'b0, half_sum};
        end else begin
          wr_word = {old_mark, half_sum};
        end
      end
      default: wr_word = old_word;
    endcase
  end

  assign ob_push = e_valid_r && fire;
  assign ob_pop  = out_chan.valid && out_chan.ready;

  assign out_chan.valid    = (ob_cnt_r != '0);
  assign out_chan.tile_row = ob_r[ob_rp_r].row;
  assign out_chan.tile_col = ob_r[ob_rp_r].col;

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (e_valid_r) begin
      mem_r[e_addr_r] <= wr_word;
    end
    if (pop) begin
      mem_rd_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e_op_r    <= head.op;
      e_addr_r  <= rd_addr;
      e_row_r   <= head.row;
      e_col_r   <= head.col;
      e_value_r <= head.value;
    end
    if (e_valid_r) begin
      fwd_addr_r <= e_addr_r;
      fwd_data_r <= wr_word;
    end
    if (ob_push) begin
      ob_r[ob_wp_r] <= '{row: e_row_r, col: e_col_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      e_valid_r    <= 1'b0;
      fwd_valid_r  <= 1'b0;
      ob_wp_r      <= 1'b0;
      ob_rp_r      <= 1'b0;
      ob_cnt_r     <= '0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(TILE_COUNT - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      e_valid_r   <= pop;
      fwd_valid_r <= e_valid_r;
      if (ob_push) begin
        ob_wp_r <= ~ob_wp_r;
      end
      if (ob_pop) begin
        ob_rp_r <= ~ob_rp_r;
      end
      priority if (ob_push && !ob_pop) begin
        ob_cnt_r <= ob_cnt_r + 1'b1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt_r <= ob_cnt_r - 1'b1;
      end else begin
        ob_cnt_r <= ob_cnt_r;
      end
    end
  end

  a_ob_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> (ob_cnt_r != 2'd2) || ob_pop)
    else $error("result buffer overflow");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !pop && !e_valid_r)
    else $error("item entered tile memory during clearing pass");

  a_fire_marks_tile: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> wr_word[SUM_W])
    else $error("fired tile not marked");

  a_ob_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2)
    else $error("result buffer count out of range");

endmodule

// ===== hdl/tile_occupancy_hysteresis.sv =====
// top level of the tile occupancy hysteresis block
// depends on toh_pkg, toh_if, toh_front, toh_queue and toh_back

// Bins range-sensor pixels of a 101 x 101 grid into 31 x 31 tiles. An add item
// (operation 0) rounds the pixel's row and column to a tile, clamps to the last
// tile, and adds pixel_value to that tile's 24-bit sum, saturating. A settle item
// (operation 1) takes the next tile of an internal row-major sweep, halves its
// sum (floor), and emits the tile's row and column once when the halved sum rises
// above fire_threshold; the tile rearms when a settle sees the halved sum below
// rearm_threshold. Sums and marks live in one 961-word memory. After reset a
// clearing pass writes zeros to it one word a cycle while in_chan ready stays
// low; configuration writes are taken throughout. Afterwards the block takes one
// item per cycle while results drain: the front maps coordinates with a
// reciprocal multiply, a 4-entry queue decouples it from the back, and the back
// does one memory read-modify-write per cycle with a forwarding register for
// back-to-back hits on the same tile. The back takes a new item only while the
// 2-entry result buffer, counting a settle still in the back, holds at most one
// result, so a run of settles that all fire waits at times for a result to
// drain, and a stalled result side pauses adds and settles alike once two
// results wait. Thresholds are written through cfg_we/cfg_index/cfg_data,
// index 0 for fire_threshold and 1 for rearm_threshold; the user must write
// them only while the block is idle, which the block does not enforce.

module tile_occupancy_hysteresis import toh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  toh_in_if.sink                in_chan,
  toh_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // threshold registers
  logic [SUM_W-1:0] fire_thr_r;
  logic [SUM_W-1:0] rearm_thr_r;
  thr_t             thr;

  // front to queue
  logic         push;
  q_entry_t     push_entry;

  // queue to back
  logic         pop;
  q_entry_t     head;
  q_status_t    q_stat;
  back_status_t back_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_thr_r  <= FIRE_RESET;
      rearm_thr_r <= REARM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRE:  fire_thr_r  <= cfg_data;
        CFG_REARM: rearm_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign thr.fire  = fire_thr_r;
  assign thr.rearm = rearm_thr_r;

  // classify and map incoming items
  toh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_stat     (q_stat),
    .back_stat  (back_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  toh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // tile memory update and result buffer
  toh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .thr      (thr),
    .pop      (pop),
    .stat     (back_stat),
    .out_chan (out_chan)
  );

endmodule
